// ----- rtl/aarf_pkg.sv -----
// ----------------------------------------------------------------------------
// aarf_pkg: shared definitions for the address allowlist filter
// Action codes, field widths, reset constants and controller/datapath links.
// ----------------------------------------------------------------------------
package aarf_pkg;

  localparam int ADDR_W              = 48;
  localparam int RSSI_W              = 8;
  localparam int COUNT_OUT_W         = 4;
  localparam int TABLE_DEPTH_DEFAULT = 8;

  localparam logic signed [RSSI_W-1:0] RSSI_THRESHOLD_RESET = -8'sd80;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_ADVERT = 2'd3
  } action_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // capture input transaction, restart the scan
    logic rd;          // read the entry under the scan pointer
    logic eval;        // compare read entry, compact on remove
    logic shift_init;  // point at entry 1 for the drop-oldest pass
    logic shift_rd;    // read entry for the drop-oldest pass
    logic shift_wr;    // move read entry one slot down
    logic append;      // write the new address at the tail
    logic finish;      // commit state, load the result register
  } aarf_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    action_t act;
    logic    scan_done;
    logic    found;
    logic    full;
    logic    shift_done;
    logic    out_free;
  } aarf_stat_t;

endpackage

// ----- rtl/address_allowlist_rssi_filter_unit.sv -----
// ----------------------------------------------------------------------------
// address_allowlist_rssi_filter_unit: address accept list with presence check
// Ordered list of device addresses with add, remove, clear and advert check.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, action, address, rssi) carries one
//   transaction per item; it is taken on a clock edge with in_valid high and
//   in_stall low. Output channel (out_valid / out_stall, ok, entry_count,
//   newest_address, present) returns exactly one result per transaction.
//   cfg_valid / cfg_ready writes rssi_threshold (cfg_ready is always high);
//   write it only while no transaction is in flight.
// Timing:
//   One transaction at a time. The sequencer scans the list one entry at a
//   time through the entry memory, reading each entry and then evaluating
//   it; an add of an unlisted address to a full list runs the drop-oldest
//   shift before the append. Clear skips the scan.
// Reset:
//   rst (synchronous) empties the list, clears the presence flag, drops any
//   pending result and restores the threshold to -80 dBm.
// Stall:
//   A finished result waits in the output register while out_stall is high;
//   the next transaction is accepted and processed meanwhile, and holds in
//   its final step until the output register frees up.
// ----------------------------------------------------------------------------
module address_allowlist_rssi_filter_unit #(
  parameter int TABLE_DEPTH = aarf_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         action,
  input  logic [aarf_pkg::ADDR_W-1:0]        address,
  input  logic signed [aarf_pkg::RSSI_W-1:0] rssi,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               ok,
  output logic [aarf_pkg::COUNT_OUT_W-1:0]   entry_count,
  output logic [aarf_pkg::ADDR_W-1:0]        newest_address,
  output logic                               present,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic signed [aarf_pkg::RSSI_W-1:0] cfg_data
);
  import aarf_pkg::*;

  aarf_cmd_t  cmd;
  aarf_stat_t stat;

  // Threshold writes are always taken
  assign cfg_ready = 1'b1;

  // Sequencer: advance each transaction through its steps
  aarf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Entry memory, pointers, flags and result register
  aarf_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .action         (action),
    .address        (address),
    .rssi           (rssi),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .ok             (ok),
    .entry_count    (entry_count),
    .newest_address (newest_address),
    .present        (present),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule

// ----- rtl/aarf_ctrl.sv -----
// ----------------------------------------------------------------------------
// aarf_ctrl: sequencer for the address allowlist filter
// Steps each transaction through scan, drop-oldest shift, append and result.
// ----------------------------------------------------------------------------
module aarf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  aarf_pkg::aarf_stat_t stat,
  output aarf_pkg::aarf_cmd_t  cmd
);
  import aarf_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SCAN   = 7'b0000010,
    ST_EVAL   = 7'b0000100,
    ST_SHIFT  = 7'b0001000,
    ST_SHWR   = 7'b0010000,
    ST_APPEND = 7'b0100000,
    ST_FIN    = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.scan_done) begin
          if (stat.act == ACT_ADD && !stat.found) begin
            if (stat.full) begin
              cmd.shift_init = 1'b1;
              state_next     = ST_SHIFT;
            end else begin
              state_next = ST_APPEND;
            end
          end else begin
            state_next = ST_FIN;
          end
        end else begin
          cmd.rd     = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SHIFT: begin
        if (stat.shift_done) begin
          state_next = ST_APPEND;
        end else begin
          cmd.shift_rd = 1'b1;
          state_next   = ST_SHWR;
        end
      end
      ST_SHWR: begin
        cmd.shift_wr = 1'b1;
        state_next   = ST_SHIFT;
      end
      ST_APPEND: begin
        cmd.append = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/aarf_dp.sv -----
// ----------------------------------------------------------------------------
// aarf_dp: datapath for the address allowlist filter
// Entry memory, scan and write pointers, threshold, flags and result register.
// ----------------------------------------------------------------------------
module aarf_dp #(
  parameter int TABLE_DEPTH = aarf_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [1:0]                        action,
  input  logic [aarf_pkg::ADDR_W-1:0]       address,
  input  logic signed [aarf_pkg::RSSI_W-1:0] rssi,
  input  logic                              cfg_valid,
  input  logic signed [aarf_pkg::RSSI_W-1:0] cfg_data,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic                              ok,
  output logic [aarf_pkg::COUNT_OUT_W-1:0]  entry_count,
  output logic [aarf_pkg::ADDR_W-1:0]       newest_address,
  output logic                              present,
  input  aarf_pkg::aarf_cmd_t               cmd,
  output aarf_pkg::aarf_stat_t              stat
);
  import aarf_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] LAST_C  = CW'(TABLE_DEPTH - 1);

  logic [ADDR_W-1:0] mem [TABLE_DEPTH];
  logic [ADDR_W-1:0] rd_data;

  action_t                  act;
  logic [ADDR_W-1:0]        addr_r;
  logic signed [RSSI_W-1:0] rssi_r;
  logic signed [RSSI_W-1:0] thr;
  logic [CW-1:0]            count;
  logic [CW-1:0]            idx;
  logic [CW-1:0]            widx;
  logic                     found;
  logic                     flag;
  logic [ADDR_W-1:0]        newest;

  logic [CW-1:0]            idx_m1;
  logic [CW-1:0]            app_ptr;
  logic                     hit;
  logic                     we;
  logic [AW-1:0]            waddr;
  logic [ADDR_W-1:0]        wdata;
  logic                     ok_next;
  logic [CW-1:0]            count_next;
  logic [ADDR_W-1:0]        newest_next;
  logic                     flag_next;
  logic [CW+COUNT_OUT_W-1:0] count_ext;

  assign idx_m1  = idx - CW'(1);
  assign app_ptr = (count == DEPTH_C) ? LAST_C : count;
  assign hit     = (rd_data == addr_r);

  // Single write port: compaction, drop-oldest shift or tail append
  always_comb begin
    we    = 1'b0;
    waddr = widx[AW-1:0];
    wdata = rd_data;
    if (cmd.eval && act == ACT_REMOVE && !hit) begin
      we = 1'b1;
    end else if (cmd.shift_wr) begin
      we    = 1'b1;
      waddr = idx_m1[AW-1:0];
    end else if (cmd.append) begin
      we    = 1'b1;
      waddr = app_ptr[AW-1:0];
      wdata = addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd || cmd.shift_rd) begin
      rd_data <= mem[idx[AW-1:0]];
    end
  end

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= RSSI_THRESHOLD_RESET;
    end else if (cfg_valid) begin
      thr <= cfg_data;
    end
  end

  // Transaction capture, scan and shift pointers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act    <= action_t'(action);
      addr_r <= address;
      rssi_r <= rssi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      widx  <= '0;
      found <= 1'b0;
    end else if (cmd.load) begin
      idx   <= '0;
      widx  <= '0;
      found <= 1'b0;
    end else if (cmd.eval) begin
      idx <= idx + CW'(1);
      if (hit) begin
        found <= 1'b1;
      end else begin
        widx <= widx + CW'(1);
      end
    end else if (cmd.shift_init) begin
      idx <= CW'(1);
    end else if (cmd.shift_wr) begin
      idx <= idx + CW'(1);
    end
  end

  // Result of the transaction
  always_comb begin
    ok_next     = 1'b0;
    count_next  = count;
    newest_next = newest;
    flag_next   = flag;
    case (act)
      ACT_ADD: begin
        ok_next = !found;
      end
      ACT_REMOVE: begin
        ok_next    = found;
        count_next = widx;
      end
      ACT_CLEAR: begin
        ok_next     = 1'b1;
        count_next  = '0;
        newest_next = '0;
      end
      ACT_ADVERT: begin
        ok_next = found && (rssi_r >= thr);
        if (ok_next) begin
          flag_next = 1'b1;
        end
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  // List state: count, newest entry, sticky presence
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      flag   <= 1'b0;
      newest <= '0;
    end else begin
      if (cmd.load && action_t'(action) == ACT_REMOVE) begin
        newest <= '0;
      end else if (cmd.eval && act == ACT_REMOVE && !hit) begin
        newest <= rd_data;
      end else if (cmd.append) begin
        newest <= addr_r;
        count  <= app_ptr + CW'(1);
      end else if (cmd.finish) begin
        count  <= count_next;
        newest <= newest_next;
        flag   <= flag_next;
      end
    end
  end

  assign count_ext = {{COUNT_OUT_W{1'b0}}, count_next};

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      ok             <= ok_next;
      entry_count    <= count_ext[COUNT_OUT_W-1:0];
      newest_address <= newest_next;
      present        <= flag_next;
    end
  end

  assign stat.act        = act;
  assign stat.scan_done  = (idx == count) || (act == ACT_CLEAR);
  assign stat.found      = found;
  assign stat.full       = (count == DEPTH_C);
  assign stat.shift_done = (idx == DEPTH_C);
  assign stat.out_free   = !out_valid || !out_stall;

endmodule

// ----- dv/allowlist_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allowlist_checker: result predictor and scoreboard for the address filter
// Watches the input, output and threshold channels, keeps a shadow copy of
// the address list and compares every delivered result with the oldest one
// predicted.
// ----------------------------------------------------------------------------
module allowlist_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [1:0]                         action,
  input  logic [aarf_pkg::ADDR_W-1:0]        address,
  input  logic signed [aarf_pkg::RSSI_W-1:0] rssi,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic                               ok,
  input  logic [aarf_pkg::COUNT_OUT_W-1:0]   entry_count,
  input  logic [aarf_pkg::ADDR_W-1:0]        newest_address,
  input  logic                               present,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic signed [aarf_pkg::RSSI_W-1:0] cfg_data,
  output int                                 fails,
  output int                                 pending
);
  import aarf_pkg::*;

  localparam int LIST_DEPTH = TABLE_DEPTH_DEFAULT;

  typedef struct packed {
    logic                   ok;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic [ADDR_W-1:0]      newest;
    logic                   present;
  } filter_result_t;

  // Shadow state of the block
  logic [ADDR_W-1:0]        shadow_list [LIST_DEPTH];
  int                       shadow_len;
  logic                     shadow_present;
  logic signed [RSSI_W-1:0] shadow_threshold;

  filter_result_t           expected_results [$];
  int                       mismatch_count = 0;

  assign fails = mismatch_count;

  function automatic filter_result_t apply_list_action(
    input action_t                  act,
    input logic [ADDR_W-1:0]        addr,
    input logic signed [RSSI_W-1:0] strength
  );
    filter_result_t res;
    logic           listed;
    logic           hit;
    int             keep;
    listed = 1'b0;
    hit    = 1'b0;
    keep   = 0;
    for (int i = 0; i < shadow_len; i++) begin
      if (shadow_list[i] == addr) listed = 1'b1;
    end
    case (act)
      ACT_ADD: begin
        if (!listed) begin
          // drop the oldest entry when the list is full
          if (shadow_len >= LIST_DEPTH) begin
            for (int i = 1; i < LIST_DEPTH; i++) shadow_list[i-1] = shadow_list[i];
            shadow_len = LIST_DEPTH - 1;
          end
          shadow_list[shadow_len] = addr;
          shadow_len++;
          hit = 1'b1;
        end
      end
      ACT_REMOVE: begin
        for (int i = 0; i < shadow_len; i++) begin
          if (shadow_list[i] == addr) begin
            hit = 1'b1;
          end else begin
            shadow_list[keep] = shadow_list[i];
            keep++;
          end
        end
        shadow_len = keep;
      end
      ACT_CLEAR: begin
        shadow_len = 0;
        hit        = 1'b1;
      end
      default: begin
        if (listed && strength >= shadow_threshold) begin
          hit            = 1'b1;
          shadow_present = 1'b1;
        end
      end
    endcase
    res.ok          = hit;
    res.entry_count = COUNT_OUT_W'(shadow_len);
    res.newest      = (shadow_len > 0) ? shadow_list[shadow_len-1] : '0;
    res.present     = shadow_present;
    return res;
  endfunction

  always @(posedge clk) begin
    filter_result_t exp_res;
    filter_result_t new_res;
    if (rst) begin
      shadow_len       = 0;
      shadow_present   = 1'b0;
      shadow_threshold = RSSI_THRESHOLD_RESET;
      expected_results.delete();
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected: ok %0d count %0d newest %h present %0d",
                   $time, ok, entry_count, newest_address, present);
          mismatch_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (ok !== exp_res.ok) begin
            $display("%0t: ok mismatch: expected %0d, actual %0d", $time, exp_res.ok, ok);
            mismatch_count++;
          end
          if (entry_count !== exp_res.entry_count) begin
            $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                     $time, exp_res.entry_count, entry_count);
            mismatch_count++;
          end
          if (newest_address !== exp_res.newest) begin
            $display("%0t: newest_address mismatch: expected %h, actual %h",
                     $time, exp_res.newest, newest_address);
            mismatch_count++;
          end
          if (present !== exp_res.present) begin
            $display("%0t: present mismatch: expected %0d, actual %0d",
                     $time, exp_res.present, present);
            mismatch_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) shadow_threshold = cfg_data;
      if (in_valid && !in_stall) begin
        new_res          = apply_list_action(action_t'(action), address, rssi);
        expected_results = {expected_results, new_res};
      end
      pending <= expected_results.size();
    end
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression for the address allowlist RSSI filter
// Directed list operations and threshold corner cases, then random phases
// over a small address pool with random idling on both channels; a checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import aarf_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 150;
  localparam int POOL_MAX     = 16;
  localparam int TAIL_CYCLES  = 60;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic [1:0]               action;
  logic [ADDR_W-1:0]        address;
  logic signed [RSSI_W-1:0] rssi;
  logic                     out_valid;
  logic                     out_stall;
  logic                     ok;
  logic [COUNT_OUT_W-1:0]   entry_count;
  logic [ADDR_W-1:0]        newest_address;
  logic                     present;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic signed [RSSI_W-1:0] cfg_data;

  int                       fails;
  int                       pending;
  int                       cycle_count = 0;

  // Stretch with no idling on either side
  logic                     calm = 1'b0;

  // Current threshold, mirrored here only to aim advert strengths near it
  logic signed [RSSI_W-1:0] cur_threshold = RSSI_THRESHOLD_RESET;

  // Small address pool so adds collide, the list fills and removes hit
  logic [ADDR_W-1:0]        addr_pool [POOL_MAX];
  int                       pool_size = 8;

  address_allowlist_rssi_filter_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .address        (address),
    .rssi           (rssi),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .ok             (ok),
    .entry_count    (entry_count),
    .newest_address (newest_address),
    .present        (present),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  allowlist_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .address        (address),
    .rssi           (rssi),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .ok             (ok),
    .entry_count    (entry_count),
    .newest_address (newest_address),
    .present        (present),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .fails          (fails),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Output side: hold stall for a random number of cycles before each
  // result, then release and wait until a result is taken.
  initial begin
    int hold;
    out_stall <= 1'b0;
    forever begin
      hold = calm ? 0 : $urandom_range(0, 9);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    return ADDR_W'({$urandom(), $urandom()});
  endfunction

  // Idle for a random gap, present one transaction and hold it until taken.
  task automatic send_item(input action_t act, input logic [ADDR_W-1:0] addr,
                           input logic signed [RSSI_W-1:0] strength);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    address  <= addr;
    rssi     <= strength;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Write the threshold only while the block is idle.
  task automatic write_threshold(input logic signed [RSSI_W-1:0] value);
    drain();
    cfg_valid     <= 1'b1;
    cfg_data      <= value;
    cur_threshold  = value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed traffic over the pool; some addresses are noise.
  task automatic send_random_item();
    int                       pick;
    int                       aimed;
    action_t                  act;
    logic [ADDR_W-1:0]        addr;
    logic signed [RSSI_W-1:0] strength;
    pick = $urandom_range(0, 99);
    if (pick < 40)      act = ACT_ADD;
    else if (pick < 60) act = ACT_REMOVE;
    else if (pick < 64) act = ACT_CLEAR;
    else                act = ACT_ADVERT;
    if ($urandom_range(0, 9) == 0) addr = rand_addr();
    else                           addr = addr_pool[$urandom_range(0, pool_size - 1)];
    if ($urandom_range(0, 1) == 0) begin
      strength = RSSI_W'($urandom_range(0, 255));
    end else begin
      // aim close to the threshold so both sides of the compare show up
      aimed = int'(cur_threshold) + int'($urandom_range(0, 6)) - 3;
      if (aimed > 127)  aimed = 127;
      if (aimed < -128) aimed = -128;
      strength = RSSI_W'(aimed);
    end
    send_item(act, addr, strength);
  endtask

  initial begin
    logic [ADDR_W-1:0]        probe;
    logic signed [RSSI_W-1:0] phase_threshold;

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    action    <= ACT_ADD;
    address   <= '0;
    rssi      <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty list, duplicates, threshold edge, overflow, compaction
    send_item(ACT_ADVERT, '0, -8'sd128);
    send_item(ACT_REMOVE, '0, 8'sd0);
    send_item(ACT_ADD,    '0, 8'sd0);
    send_item(ACT_ADD,    '1, 8'sd127);
    send_item(ACT_ADD,    '1, -8'sd1);
    send_item(ACT_ADVERT, '1, -8'sd80);
    send_item(ACT_ADVERT, '0, -8'sd81);
    send_item(ACT_ADVERT, 48'h1234_5678_9abc, 8'sd127);
    // seven more adds: fill the list, then push the oldest out
    for (int i = 0; i < 7; i++) send_item(ACT_ADD, 48'h5a00_0000_0000 + ADDR_W'(i), 8'sd0);
    send_item(ACT_REMOVE, 48'h5a00_0000_0003, 8'sd0);
    send_item(ACT_REMOVE, '0, 8'sd0);
    send_item(ACT_CLEAR,  '1, 8'sd0);
    send_item(ACT_ADVERT, '1, 8'sd127);

    // Threshold extremes, exact compare at each end
    probe = 48'h8000_0000_0001;
    write_threshold(8'sd127);
    send_item(ACT_ADD,    probe, 8'sd0);
    send_item(ACT_ADVERT, probe, 8'sd127);
    send_item(ACT_ADVERT, probe, 8'sd126);
    write_threshold(-8'sd128);
    send_item(ACT_ADVERT, probe, -8'sd128);

    // Random phases, each starting from an idle block with a new threshold
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       phase_threshold = 8'sd127;
        1:       phase_threshold = -8'sd128;
        2:       phase_threshold = 8'sd0;
        3:       phase_threshold = -8'sd80;
        4:       phase_threshold = -8'sd1;
        default: phase_threshold = RSSI_W'($urandom_range(0, 255));
      endcase
      write_threshold(phase_threshold);
      pool_size = $urandom_range(4, POOL_MAX - 2);
      for (int i = 0; i < POOL_MAX; i++) addr_pool[i] = rand_addr();
      if ($urandom_range(0, 1) == 0) addr_pool[0] = '0;
      if ($urandom_range(0, 1) == 0) addr_pool[1] = '1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // change idling behavior every few dozen transactions
        if (n % 50 == 0) calm = ($urandom_range(0, 3) == 0);
        send_random_item();
      end
      calm = 1'b0;
    end

    // Wait for the last results, then a margin for anything stray
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- address_allowlist_rssi_filter_unit.f -----
rtl/aarf_pkg.sv
rtl/aarf_ctrl.sv
rtl/aarf_dp.sv
rtl/address_allowlist_rssi_filter_unit.sv
dv/allowlist_checker.sv
dv/tb.sv
